[src/sha512_message_hasher_unit_assert.svh]
// Assertion macros for the SHA-512 message hasher.
`ifndef SHA512_MESSAGE_HASHER_UNIT_ASSERT_SVH
`define SHA512_MESSAGE_HASHER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SHA512MH_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHA512MH_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sha512mh_pkg.sv]
// Shared types, constants and round functions for the SHA-512 message hasher.
package sha512mh_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPD,
        ST_PAD,
        ST_OUTRD,
        ST_OUTCAP
    } state_t;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN_LO,
        PH_DONE
    } pad_phase_t;

    typedef struct packed {
        logic       rd_en;
        logic [2:0] rd_addr;
        logic       cap_load;
        logic       round;
        logic       upd;
        logic [2:0] idx;
        logic       fresh;
    } core_ctl_t;

    localparam int unsigned NumRounds = 80;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] iv_word(input logic [2:0] i);
        logic [63:0] r;
        unique case (i)
            3'd0: r = 64'h6A09E667F3BCC908;
            3'd1: r = 64'hBB67AE8584CAA73B;
            3'd2: r = 64'h3C6EF372FE94F82B;
            3'd3: r = 64'hA54FF53A5F1D36F1;
            3'd4: r = 64'h510E527FADE682D1;
            3'd5: r = 64'h9B05688C2B3E6C1F;
            3'd6: r = 64'h1F83D9ABFB41BD6B;
            3'd7: r = 64'h5BE0CD19137E2179;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] k_word(input logic [6:0] t);
        logic [63:0] r;
        case (t)
            7'd0:  r = 64'h428A2F98D728AE22;
            7'd1:  r = 64'h7137449123EF65CD;
            7'd2:  r = 64'hB5C0FBCFEC4D3B2F;
            7'd3:  r = 64'hE9B5DBA58189DBBC;
            7'd4:  r = 64'h3956C25BF348B538;
            7'd5:  r = 64'h59F111F1B605D019;
            7'd6:  r = 64'h923F82A4AF194F9B;
            7'd7:  r = 64'hAB1C5ED5DA6D8118;
            7'd8:  r = 64'hD807AA98A3030242;
            7'd9:  r = 64'h12835B0145706FBE;
            7'd10: r = 64'h243185BE4EE4B28C;
            7'd11: r = 64'h550C7DC3D5FFB4E2;
            7'd12: r = 64'h72BE5D74F27B896F;
            7'd13: r = 64'h80DEB1FE3B1696B1;
            7'd14: r = 64'h9BDC06A725C71235;
            7'd15: r = 64'hC19BF174CF692694;
            7'd16: r = 64'hE49B69C19EF14AD2;
            7'd17: r = 64'hEFBE4786384F25E3;
            7'd18: r = 64'h0FC19DC68B8CD5B5;
            7'd19: r = 64'h240CA1CC77AC9C65;
            7'd20: r = 64'h2DE92C6F592B0275;
            7'd21: r = 64'h4A7484AA6EA6E483;
            7'd22: r = 64'h5CB0A9DCBD41FBD4;
            7'd23: r = 64'h76F988DA831153B5;
            7'd24: r = 64'h983E5152EE66DFAB;
            7'd25: r = 64'hA831C66D2DB43210;
            7'd26: r = 64'hB00327C898FB213F;
            7'd27: r = 64'hBF597FC7BEEF0EE4;
            7'd28: r = 64'hC6E00BF33DA88FC2;
            7'd29: r = 64'hD5A79147930AA725;
            7'd30: r = 64'h06CA6351E003826F;
            7'd31: r = 64'h142929670A0E6E70;
            7'd32: r = 64'h27B70A8546D22FFC;
            7'd33: r = 64'h2E1B21385C26C926;
            7'd34: r = 64'h4D2C6DFC5AC42AED;
            7'd35: r = 64'h53380D139D95B3DF;
            7'd36: r = 64'h650A73548BAF63DE;
            7'd37: r = 64'h766A0ABB3C77B2A8;
            7'd38: r = 64'h81C2C92E47EDAEE6;
            7'd39: r = 64'h92722C851482353B;
            7'd40: r = 64'hA2BFE8A14CF10364;
            7'd41: r = 64'hA81A664BBC423001;
            7'd42: r = 64'hC24B8B70D0F89791;
            7'd43: r = 64'hC76C51A30654BE30;
            7'd44: r = 64'hD192E819D6EF5218;
            7'd45: r = 64'hD69906245565A910;
            7'd46: r = 64'hF40E35855771202A;
            7'd47: r = 64'h106AA07032BBD1B8;
            7'd48: r = 64'h19A4C116B8D2D0C8;
            7'd49: r = 64'h1E376C085141AB53;
            7'd50: r = 64'h2748774CDF8EEB99;
            7'd51: r = 64'h34B0BCB5E19B48A8;
            7'd52: r = 64'h391C0CB3C5C95A63;
            7'd53: r = 64'h4ED8AA4AE3418ACB;
            7'd54: r = 64'h5B9CCA4F7763E373;
            7'd55: r = 64'h682E6FF3D6B2B8A3;
            7'd56: r = 64'h748F82EE5DEFB2FC;
            7'd57: r = 64'h78A5636F43172F60;
            7'd58: r = 64'h84C87814A1F0AB72;
            7'd59: r = 64'h8CC702081A6439EC;
            7'd60: r = 64'h90BEFFFA23631E28;
            7'd61: r = 64'hA4506CEBDE82BDE9;
            7'd62: r = 64'hBEF9A3F7B2C67915;
            7'd63: r = 64'hC67178F2E372532B;
            7'd64: r = 64'hCA273ECEEA26619C;
            7'd65: r = 64'hD186B8C721C0C207;
            7'd66: r = 64'hEADA7DD6CDE0EB1E;
            7'd67: r = 64'hF57D4F7FEE6ED178;
            7'd68: r = 64'h06F067AA72176FBA;
            7'd69: r = 64'h0A637DC5A2C898A6;
            7'd70: r = 64'h113F9804BEF90DAE;
            7'd71: r = 64'h1B710B35131C471B;
            7'd72: r = 64'h28DB77F523047D84;
            7'd73: r = 64'h32CAAB7B40C72493;
            7'd74: r = 64'h3C9EBE0A15C9BEBC;
            7'd75: r = 64'h431D67C49C100D4C;
            7'd76: r = 64'h4CC5D4BECB3E42B6;
            7'd77: r = 64'h597F299CFC657E2A;
            7'd78: r = 64'h5FCB6FAB3AD6FAEC;
            7'd79: r = 64'h6C44198C4A475817;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[src/sha512mh_sched.sv]
// Sixteen-word block buffer and rolling SHA-512 message schedule.
module sha512mh_sched
    import sha512mh_pkg::*;
(
    input  logic        clk,
    input  logic        push,
    input  logic [63:0] push_data,
    input  logic        adv,
    input  logic        early,
    output logic [63:0] wt
);

    logic [63:0] w_reg [16];
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] w_new;
    logic [63:0] shift_in;

    always_comb
    begin
        s0 = rotr(w_reg[1], 1) ^ rotr(w_reg[1], 8) ^ (w_reg[1] >> 7);
        s1 = rotr(w_reg[14], 19) ^ rotr(w_reg[14], 61) ^ (w_reg[14] >> 6);
        w_new = w_reg[0] + s0 + s1 + w_reg[9];
        wt = early ? w_reg[0] : w_new;
        shift_in = push ? push_data : wt;
    end

    always_ff @(posedge clk)
    begin
        if (push || adv)
        begin
            for (int k = 0; k < 15; k++)
            begin
                w_reg[k] <= w_reg[k + 1];
            end
            w_reg[15] <= shift_in;
        end
    end

endmodule

[src/sha512mh_core.sv]
// Digest memory, working variables and the SHA-512 round datapath.
module sha512mh_core
    import sha512mh_pkg::*;
(
    input  logic        clk,
    input  core_ctl_t   ctl,
    input  logic [63:0] wt,
    input  logic [63:0] kt,
    output logic [63:0] rdata
);

    logic [63:0] mem [8];
    logic [63:0] rdata_reg;
    logic [63:0] v_reg [8];
    logic [63:0] src;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] big_s1;
    logic [63:0] big_s0;
    logic [63:0] ch;
    logic [63:0] maj;

    assign rdata = rdata_reg;

    always_comb
    begin
        src = ctl.fresh ? iv_word(ctl.idx) : rdata_reg;
        big_s1 = rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big_s1 + ch + kt + wt;
        big_s0 = rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big_s0 + maj;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.upd)
        begin
            mem[ctl.idx] <= src + v_reg[0];
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[ctl.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_load)
        begin
            for (int k = 0; k < 7; k++)
            begin
                v_reg[k] <= v_reg[k + 1];
            end
            v_reg[7] <= src;
        end
        else if (ctl.upd)
        begin
            for (int k = 0; k < 7; k++)
            begin
                v_reg[k] <= v_reg[k + 1];
            end
            v_reg[7] <= v_reg[0];
        end
        else if (ctl.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

[src/sha512_message_hasher_unit.sv]
// Top level of the SHA-512 message hasher.
//
//   channel | direction | payload
//   s_*     | in        | msg_word, valid_bytes, last_word (tlast)
//   m_*     | out       | digest_word, word_bytes, last_out (tlast)
//   cfg_*   | in        | digest_bytes
//
// Words are accepted only in the idle state; each full block then goes through
// an 8-word digest load, 80 rounds and an 8-word digest write-back via the digest
// memory. The final word adds the padding words plus one or two compressions;
// each digest word then waits for the previous transfer, is read from memory and
// is captured in the output register, and can be held by any stall on m_tready.
// Reset is asynchronous and needs no clearing pass.
module sha512_message_hasher_unit
    import sha512mh_pkg::*;
#(
    parameter int LEN_COUNTER_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] msg_word, [67:64] valid_bytes, zero fill
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] digest_word, [67:64] word_bytes, zero fill
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    state_t                      state_reg, state_next;
    pad_phase_t                  ph_reg, ph_next;
    logic [6:0]                  cnt_reg, cnt_next;
    logic [3:0]                  fill_reg, fill_next;
    logic [63:0]                 acc_reg, acc_next;
    logic [2:0]                  pos_reg, pos_next;
    logic [LEN_COUNTER_BITS-1:0] bitlen_reg, bitlen_next;
    logic                        fin_reg, fin_next;
    logic                        fresh_reg, fresh_next;
    logic [2:0]                  oi_reg, oi_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [63:0]                 out_data_reg, out_data_next;
    logic [3:0]                  out_bytes_reg, out_bytes_next;
    logic                        out_last_reg, out_last_next;
    logic [6:0]                  cfg_reg;

    core_ctl_t   ctl;
    logic        push;
    logic [63:0] push_data;
    logic        adv;
    logic [63:0] wt;
    logic [63:0] rdata;

    logic [3:0]   vbc;
    logic [63:0]  msg_m;
    logic [127:0] comb_w;
    logic [3:0]   tot;
    logic [127:0] len_field;
    logic [6:0]   total;
    logic [3:0]   nw;
    logic [6:0]   left;
    logic [3:0]   nbytes;
    logic         s_acc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {4'b0000, out_bytes_reg, out_data_reg};
    assign m_tlast   = out_last_reg;

    sha512mh_sched u_sched (
        .clk       (clk),
        .push      (push),
        .push_data (push_data),
        .adv       (adv),
        .early     (cnt_reg < 7'd16),
        .wt        (wt)
    );

    sha512mh_core u_core (
        .clk   (clk),
        .ctl   (ctl),
        .wt    (wt),
        .kt    (k_word(cnt_reg)),
        .rdata (rdata)
    );

    always_comb
    begin
        vbc = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
        msg_m = s_tdata[63:0] & ~(64'hFFFF_FFFF_FFFF_FFFF >> {vbc, 3'b000});
        comb_w = {acc_reg, 64'd0} | ({msg_m, 64'd0} >> {pos_reg, 3'b000});
        tot = {1'b0, pos_reg} + vbc;
        len_field = 128'(bitlen_reg);
        total = (cfg_reg > 7'd64) ? 7'd64 : cfg_reg;
        nw = 4'((total + 7'd7) >> 3);
        left = total - {1'b0, oi_reg, 3'b000};
        nbytes = (left >= 7'd8) ? 4'd8 : left[3:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        cnt_next       = cnt_reg;
        fill_next      = fill_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        bitlen_next    = bitlen_reg;
        fin_next       = fin_reg;
        fresh_next     = fresh_reg;
        oi_next        = oi_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_bytes_next = out_bytes_reg;
        out_last_next  = out_last_reg;
        push           = 1'b0;
        push_data      = '0;
        adv            = 1'b0;
        ctl            = '0;
        ctl.fresh      = fresh_reg;
        ctl.rd_addr    = cnt_reg[2:0];
        ctl.idx        = cnt_reg[2:0] - 3'd1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    bitlen_next = bitlen_reg + LEN_COUNTER_BITS'({vbc, 3'b000});
                    fin_next = s_tlast;
                    ph_next = PH_MARK;
                    if (tot >= 4'd8)
                    begin
                        push = 1'b1;
                        push_data = comb_w[127:64];
                        acc_next = comb_w[63:0];
                        pos_next = 3'(tot - 4'd8);
                        fill_next = fill_reg + 4'd1;
                    end
                    else
                    begin
                        acc_next = comb_w[127:64];
                        pos_next = tot[2:0];
                    end
                    if (tot >= 4'd8 && fill_reg == 4'd15)
                    begin
                        state_next = ST_LOAD;
                        cnt_next = '0;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push = 1'b1;
                fill_next = fill_reg + 4'd1;
                unique case (ph_reg)
                    PH_MARK:
                    begin
                        push_data = acc_reg
                                  | (64'h8000_0000_0000_0000 >> {pos_reg, 3'b000});
                        acc_next = '0;
                        pos_next = '0;
                        ph_next = PH_ZERO;
                    end
                    PH_ZERO:
                    begin
                        if (fill_reg == 4'd14)
                        begin
                            push_data = len_field[127:64];
                            ph_next = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO:
                    begin
                        push_data = len_field[63:0];
                        ph_next = PH_DONE;
                    end
                    PH_DONE:
                    begin
                        push = 1'b0;
                        fill_next = fill_reg;
                    end
                endcase
                if (push && fill_reg == 4'd15)
                begin
                    state_next = ST_LOAD;
                    cnt_next = '0;
                end
            end
            ST_LOAD:
            begin
                ctl.rd_en = (cnt_reg < 7'd8);
                ctl.cap_load = (cnt_reg != 7'd0);
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd8)
                begin
                    state_next = ST_ROUND;
                    cnt_next = '0;
                end
            end
            ST_ROUND:
            begin
                ctl.round = 1'b1;
                adv = 1'b1;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(NumRounds - 1))
                begin
                    state_next = ST_UPD;
                    cnt_next = '0;
                end
            end
            ST_UPD:
            begin
                ctl.rd_en = (cnt_reg < 7'd8);
                ctl.upd = (cnt_reg != 7'd0);
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd8)
                begin
                    cnt_next = '0;
                    fresh_next = 1'b0;
                    if (!fin_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (ph_reg != PH_DONE)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        bitlen_next = '0;
                        fin_next = 1'b0;
                        ph_next = PH_MARK;
                        oi_next = '0;
                        if (nw == 4'd0)
                        begin
                            fresh_next = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_OUTRD;
                        end
                    end
                end
            end
            ST_OUTRD:
            begin
                ctl.rd_addr = oi_reg;
                if (!m_tvalid_reg)
                begin
                    ctl.rd_en = 1'b1;
                    state_next = ST_OUTCAP;
                end
            end
            ST_OUTCAP:
            begin
                m_tvalid_next = 1'b1;
                out_data_next = rdata & ~(64'hFFFF_FFFF_FFFF_FFFF >> {nbytes, 3'b000});
                out_bytes_next = nbytes;
                out_last_next = ({1'b0, oi_reg} + 4'd1 == nw);
                if ({1'b0, oi_reg} + 4'd1 == nw)
                begin
                    fresh_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    oi_next = oi_reg + 3'd1;
                    state_next = ST_OUTRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ph_reg       <= PH_MARK;
            cnt_reg      <= '0;
            fill_reg     <= '0;
            acc_reg      <= '0;
            pos_reg      <= '0;
            bitlen_reg   <= '0;
            fin_reg      <= 1'b0;
            fresh_reg    <= 1'b1;
            oi_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            cfg_reg      <= 7'd64;
        end
        else
        begin
            state_reg    <= state_next;
            ph_reg       <= ph_next;
            cnt_reg      <= cnt_next;
            fill_reg     <= fill_next;
            acc_reg      <= acc_next;
            pos_reg      <= pos_next;
            bitlen_reg   <= bitlen_next;
            fin_reg      <= fin_next;
            fresh_reg    <= fresh_next;
            oi_reg       <= oi_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_bytes_reg <= out_bytes_next;
        out_last_reg  <= out_last_next;
    end

`include "sha512_message_hasher_unit_assert.svh"

    `SHA512MH_IMPLY(a_round_range, clk, rst_n, state_reg == ST_ROUND, cnt_reg < 7'd80, "round count out of range")
    `SHA512MH_IMPLY(a_load_fill, clk, rst_n, state_reg == ST_LOAD, fill_reg == 4'd0, "block load with partial buffer")
    `SHA512MH_IMPLY(a_out_bytes, clk, rst_n, m_tvalid_reg, out_bytes_reg != 4'd0 && out_bytes_reg <= 4'd8, "bad digest byte count")
    `SHA512MH_NEXT(a_upd_idle, clk, rst_n, state_reg == ST_UPD && cnt_reg == 7'd8 && !fin_reg, state_reg == ST_IDLE, "mid-message block did not return to idle")

endmodule

[bench/sha512_message_hasher_unit_tb.sv]
// Self-checking stream testbench for the SHA-512 message hasher with a digest predictor.
`timescale 1ns / 1ps

module sha512_message_hasher_unit_tb;
    import sha512mh_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 440;
    localparam int QUIET_ITEMS = 400;

    localparam logic [63:0] HASH_INIT [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
        64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
        64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
        64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
        64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
        64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
        64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
        64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
        64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
        64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
        64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
        64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
        64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
        64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
        64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
    };

    class digest_scoreboard;
        logic [63:0] hash_words [8];
        logic [63:0] block_words [16];
        logic [63:0] byte_count;
        int unsigned digest_len;
        logic [63:0] want_word [$];
        logic [3:0]  want_bytes [$];
        logic        want_last [$];
        int errors;

        function new();
            digest_len = 64;
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
            begin
                hash_words[i] = HASH_INIT[i];
            end
            for (int i = 0; i < 16; i++)
            begin
                block_words[i] = '0;
            end
            byte_count = '0;
        endfunction

        function logic [63:0] ror(logic [63:0] x, int n);
            return (x >> n) | (x << (64 - n));
        endfunction

        function void compress();
            logic [63:0] w [16];
            logic [63:0] v [8];
            logic [63:0] wt, t1, t2, a, b;
            for (int i = 0; i < 16; i++)
            begin
                w[i] = block_words[i];
            end
            for (int i = 0; i < 8; i++)
            begin
                v[i] = hash_words[i];
            end
            for (int t = 0; t < 80; t++)
            begin
                if (t < 16)
                begin
                    wt = w[t];
                end
                else
                begin
                    a = w[(t + 1) % 16];
                    b = w[(t + 14) % 16];
                    wt = w[t % 16] + (ror(a, 1) ^ ror(a, 8) ^ (a >> 7))
                       + (ror(b, 19) ^ ror(b, 61) ^ (b >> 6)) + w[(t + 9) % 16];
                    w[t % 16] = wt;
                end
                t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + wt;
                t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
            begin
                hash_words[i] = hash_words[i] + v[i];
            end
        endfunction

        function void put_byte(int pos, logic [7:0] b);
            int wi;
            int sh;
            wi = pos / 8;
            sh = (7 - pos % 8) * 8;
            if (pos % 8 == 0)
            begin
                block_words[wi] = '0;
            end
            block_words[wi] = block_words[wi] | (64'(b) << sh);
        endfunction

        function void pad_and_close();
            int pos;
            int p;
            pos = int'(byte_count[6:0]);
            put_byte(pos, 8'h80);
            for (p = pos + 1; p % 8 != 0; p++)
            begin
                put_byte(p, 8'h00);
            end
            for (int wi = p / 8; wi < 16; wi++)
            begin
                block_words[wi] = '0;
            end
            if (pos >= 112)
            begin
                compress();
                for (int i = 0; i < 16; i++)
                begin
                    block_words[i] = '0;
                end
            end
            block_words[14] = '0;
            block_words[15] = byte_count << 3;
            compress();
        endfunction

        function void note_input(logic [63:0] word, logic [3:0] vb, logic last);
            int n;
            int total;
            int nw;
            int left;
            int nb;
            int pos;
            logic [63:0] v;
            n = (vb > 8) ? 8 : int'(vb);
            for (int i = 0; i < n; i++)
            begin
                pos = int'(byte_count[6:0]);
                put_byte(pos, word[63 - 8 * i -: 8]);
                byte_count = byte_count + 1;
                if (pos == 127)
                begin
                    compress();
                end
            end
            if (last)
            begin
                pad_and_close();
                total = (digest_len > 64) ? 64 : int'(digest_len);
                nw = (total + 7) / 8;
                for (int i = 0; i < nw; i++)
                begin
                    left = total - 8 * i;
                    nb = (left > 8) ? 8 : left;
                    v = hash_words[i];
                    if (nb < 8)
                    begin
                        v = v & ~({64{1'b1}} >> (8 * nb));
                    end
                    want_word.push_back(v);
                    want_bytes.push_back(4'(nb));
                    want_last.push_back(i == nw - 1);
                end
                restart();
            end
        endfunction

        function void check_result(logic [63:0] word, logic [3:0] wb, logic last);
            logic [63:0] ew;
            logic [3:0]  eb;
            logic        el;
            if (want_word.size() == 0)
            begin
                $display("%0t: unexpected digest word %h", $time, word);
                errors++;
                return;
            end
            ew = want_word.pop_front();
            eb = want_bytes.pop_front();
            el = want_last.pop_front();
            if (word !== ew)
            begin
                $display("%0t: digest_word expected %h actual %h", $time, ew, word);
                errors++;
            end
            if (wb !== eb)
            begin
                $display("%0t: word_bytes expected %0d actual %0d", $time, eb, wb);
                errors++;
            end
            if (last !== el)
            begin
                $display("%0t: last_out expected %0d actual %0d", $time, el, last);
                errors++;
            end
        endfunction

        function int pending();
            return want_word.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    digest_scoreboard sb;
    int  words_sent;
    int  quiet_cycles;
    bit  idling;
    bit  hold_req;

    sha512_message_hasher_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (s_tvalid && s_tready)
            begin
                sb.note_input(s_tdata[63:0], s_tdata[67:64], s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata[63:0], m_tdata[67:64], m_tlast);
            end
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL sha512_message_hasher_unit");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_word(logic [63:0] word, logic [3:0] vb, logic last);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, vb, word};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (words_sent > QUIET_ITEMS)
        begin
            idling = 1'b0;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_digest_len(logic [6:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        sb.digest_len = value;
    endtask

    function automatic logic [63:0] rand_word();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick == 1)
        begin
            return {64{1'b1}};
        end
        return {$urandom, $urandom};
    endfunction

    task automatic send_message(int nwords, bit ragged);
        logic [3:0] vb;
        for (int k = 0; k < nwords; k++)
        begin
            if (k == nwords - 1 || ragged)
            begin
                vb = 4'($urandom_range(0, 15));
            end
            else if ($urandom_range(0, 19) == 0)
            begin
                vb = 4'($urandom_range(0, 15));
            end
            else
            begin
                vb = 4'd8;
            end
            send_word(rand_word(), vb, k == nwords - 1);
        end
    endtask

    initial
    begin
        logic [6:0] settings [8];
        int msg_count;
        settings = '{7'd0, 7'd127, 7'd1, 7'd7, 7'd8, 7'd9, 7'd63, 7'd64};
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        words_sent = 0;
        quiet_cycles = 0;
        idling = 1'b1;
        hold_req = 1'b0;
        msg_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, short message, oversized and mid-message partial counts
        send_word({64{1'b1}}, 4'd0, 1'b1);
        send_word(64'h6162630000000000, 4'd3, 1'b1);
        send_word({64{1'b1}}, 4'd15, 1'b0);
        send_word(64'h0123456789ABCDEF, 4'd5, 1'b0);
        send_word(64'h0, 4'd0, 1'b0);
        send_word({64{1'b1}}, 4'd8, 1'b1);
        // padding spills into a second block
        for (int k = 0; k < 14; k++)
        begin
            send_word((k % 2 == 0) ? 64'h0 : {64{1'b1}}, 4'd8, k == 13);
        end
        write_digest_len(7'd0);
        send_word(64'h5555AAAA5555AAAA, 4'd8, 1'b1);
        write_digest_len(7'd127);
        send_word(64'hAAAA5555AAAA5555, 4'd4, 1'b1);
        write_digest_len(7'd64);

        // stall the output so the input backs up
        hold_req = 1'b1;
        while (words_sent < RANDOM_ITEMS)
        begin
            if (msg_count % 6 == 5)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    write_digest_len(7'($urandom_range(0, 127)));
                end
                else
                begin
                    write_digest_len(settings[$urandom_range(0, 7)]);
                end
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_message($urandom_range(1, 4), 1'b1);
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                send_message($urandom_range(15, 34), 1'b0);
            end
            else
            begin
                send_message($urandom_range(1, 16), 1'b0);
            end
            msg_count++;
        end
        drain();

        if (sb.errors == 0)
        begin
            $display("PASS sha512_message_hasher_unit");
        end
        else
        begin
            $display("FAIL sha512_message_hasher_unit");
        end
        $finish;
    end

endmodule
